>>> hw/rtl/thick_line_quad_expand_top_defines.svh
// Assertion macros for the thick line quad expansion block.
`ifndef THICK_LINE_QUAD_EXPAND_TOP_DEFINES_SVH
`define THICK_LINE_QUAD_EXPAND_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLQE_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLQE_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/tlqe_pkg.sv
// Shared constants and types for the thick line quad expansion block.
package tlqe_pkg;

	localparam int THICK_W   = 16;
	localparam int MAG_W     = 16;
	localparam int NUM_CELLS = MAG_W;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THICKNESS = 2'd0,
		CFG_OFFSET_X  = 2'd1,
		CFG_OFFSET_Y  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
	} cell_ctl_t;

endpackage

>>> hw/rtl/tlqe_prep.sv
// Front pipeline: deltas, squared length and squared half-thickness bounds.
module tlqe_prep #(
	parameter int W  = 24,
	parameter int PW = 87,
	parameter int SW = 99
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [W-1:0]                 ax,
	input  logic signed [W-1:0]                 ay,
	input  logic signed [W-1:0]                 bx,
	input  logic signed [W-1:0]                 by,
	input  logic [tlqe_pkg::THICK_W-1:0]        thickness,
	output tlqe_pkg::cell_ctl_t                 out_ctl,
	output logic [PW-1:0]                       out_s,
	output logic [PW-1:0]                       out_c [2],
	output logic [SW-1:0]                       out_side
);
	import tlqe_pkg::*;

	localparam int UW = W + 1;
	localparam int TW = THICK_W + UW;
	localparam int HL = TW / 2;
	localparam int HH = TW - HL;

	logic signed [W:0]    dx, dy;
	logic [UW-1:0]        udx_s1, udy_s1;
	logic [SW-1:0]        side_s1, side_s2, side_s3, side_s4;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [2*UW-1:0]      sqx_s2, sqy_s2;
	logic [TW-1:0]        t_s2 [2];
	logic [2*UW:0]        s_s3;
	logic [2*HH-1:0]      hh_s3 [2];
	logic [HH+HL-1:0]     hl_s3 [2];
	logic [2*HL-1:0]      ll_s3 [2];
	logic [PW-1:0]        s_s4;
	logic [PW-1:0]        c_s4 [2];

	assign dx = {bx[W-1], bx} - {ax[W-1], ax};
	assign dy = {by[W-1], by} - {ay[W-1], ay};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		udx_s1  <= dx[W] ? UW'(-dx) : UW'(dx);
		udy_s1  <= dy[W] ? UW'(-dy) : UW'(dy);
		side_s1 <= {(dx == '0) && (dy == '0), (!dx[W]) && (dx != '0), dy[W], by, bx, ay, ax};
		sqx_s2  <= udx_s1 * udx_s1;
		sqy_s2  <= udy_s1 * udy_s1;
		t_s2[0] <= TW'(thickness) * TW'(udy_s1);
		t_s2[1] <= TW'(thickness) * TW'(udx_s1);
		side_s2 <= side_s1;
		s_s3    <= (2*UW+1)'(sqx_s2) + (2*UW+1)'(sqy_s2);
		for (int l = 0; l < 2; l++) begin
			hh_s3[l] <= (2*HH)'(t_s2[l][TW-1:HL]) * (2*HH)'(t_s2[l][TW-1:HL]);
			hl_s3[l] <= (HH+HL)'(t_s2[l][TW-1:HL]) * (HH+HL)'(t_s2[l][HL-1:0]);
			ll_s3[l] <= (2*HL)'(t_s2[l][HL-1:0]) * (2*HL)'(t_s2[l][HL-1:0]);
		end
		side_s3 <= side_s2;
		s_s4    <= PW'(s_s3);
		for (int l = 0; l < 2; l++) begin
			c_s4[l] <= (PW'(hh_s3[l]) << (2*HL)) + (PW'(hl_s3[l]) << (HL+1))
				+ PW'(ll_s3[l]);
		end
		side_s4 <= side_s3;
	end

	assign out_ctl.valid = v_s4;
	assign out_s         = s_s4;
	assign out_c         = c_s4;
	assign out_side      = side_s4;

endmodule

>>> hw/rtl/tlqe_cell.sv
// One bit cell of the side-vector magnitude search, both components.
module tlqe_cell #(
	parameter int PW  = 87,
	parameter int SW  = 99,
	parameter int BIT = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlqe_pkg::cell_ctl_t          in_ctl,
	input  logic [PW-1:0]                in_s,
	input  logic [PW-1:0]                in_c [2],
	input  logic [PW-1:0]                in_p [2],
	input  logic [PW-1:0]                in_q [2],
	input  logic [tlqe_pkg::MAG_W-1:0]   in_acc [2],
	input  logic [SW-1:0]                in_side,
	output tlqe_pkg::cell_ctl_t          out_ctl,
	output logic [PW-1:0]                out_s,
	output logic [PW-1:0]                out_c [2],
	output logic [PW-1:0]                out_p [2],
	output logic [PW-1:0]                out_q [2],
	output logic [tlqe_pkg::MAG_W-1:0]   out_acc [2],
	output logic [SW-1:0]                out_side
);
	import tlqe_pkg::*;

	logic signed [PW-1:0] pt [2];
	logic                 take [2];
	cell_ctl_t            ctl_q;
	logic [PW-1:0]        s_q;
	logic [PW-1:0]        c_q [2];
	logic [PW-1:0]        p_q [2];
	logic [PW-1:0]        q_q [2];
	logic [MAG_W-1:0]     acc_q [2];
	logic [SW-1:0]        side_q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			pt[l]   = $signed(in_p[l]) + ($signed(in_q[l]) <<< (BIT + 2))
				+ ($signed(in_s) <<< (2*BIT + 2));
			take[l] = pt[l] <= $signed(in_c[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		s_q    <= in_s;
		side_q <= in_side;
		for (int l = 0; l < 2; l++) begin
			c_q[l] <= in_c[l];
			if (take[l]) begin
				p_q[l]   <= pt[l];
				q_q[l]   <= in_q[l] + (in_s << (BIT + 1));
				acc_q[l] <= in_acc[l] | (MAG_W'(1) << BIT);
			end else begin
				p_q[l]   <= in_p[l];
				q_q[l]   <= in_q[l];
				acc_q[l] <= in_acc[l];
			end
		end
	end

	assign out_ctl  = ctl_q;
	assign out_s    = s_q;
	assign out_c    = c_q;
	assign out_p    = p_q;
	assign out_q    = q_q;
	assign out_acc  = acc_q;
	assign out_side = side_q;

endmodule

>>> hw/rtl/thick_line_quad_expand_top.sv
// Top level of the thick line quad expansion block.
// Takes one segment per clock whenever start is high; busy stays low, so every request is
// taken. The four corners and the degenerate flag are shown on done after four front
// stages (deltas, squares, squared bounds), sixteen search cells, one per magnitude bit
// from the most significant down, and one output register, with the first front stage
// loaded at the request edge.
// Results cannot be held off; the receiver must take done in the cycle it is shown.
// Write the configuration registers only while no request is in flight.
module thick_line_quad_expand_top #(
	parameter int COORD_WIDTH = 24,
	localparam int CFG_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_WIDTH-1:0]        start_x,
	input  logic signed [COORD_WIDTH-1:0]        start_y,
	input  logic signed [COORD_WIDTH-1:0]        end_x,
	input  logic signed [COORD_WIDTH-1:0]        end_y,
	input  logic                                 cfg_we,
	input  logic [tlqe_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]                     cfg_wdata,
	output logic                                 done,
	output logic signed [COORD_WIDTH-1:0]        corner0_x,
	output logic signed [COORD_WIDTH-1:0]        corner0_y,
	output logic signed [COORD_WIDTH-1:0]        corner1_x,
	output logic signed [COORD_WIDTH-1:0]        corner1_y,
	output logic signed [COORD_WIDTH-1:0]        corner2_x,
	output logic signed [COORD_WIDTH-1:0]        corner2_y,
	output logic signed [COORD_WIDTH-1:0]        corner3_x,
	output logic signed [COORD_WIDTH-1:0]        corner3_y,
	output logic                                 degenerate
);
	import tlqe_pkg::*;
	`include "thick_line_quad_expand_top_defines.svh"

	localparam int W   = COORD_WIDTH;
	localparam int UW  = W + 1;
	localparam int PW  = 2*UW + 37;
	localparam int SW  = 4*W + 3;
	localparam int EW  = ((W > MAG_W + 1) ? W : MAG_W + 1) + 3;
	localparam int LAT = NUM_CELLS + 5;

	logic [THICK_W-1:0]   thick_q;
	logic signed [W-1:0]  offx_q, offy_q;

	cell_ctl_t            ch_ctl  [NUM_CELLS+1];
	logic [PW-1:0]        ch_s    [NUM_CELLS+1];
	logic [PW-1:0]        ch_c    [NUM_CELLS+1][2];
	logic [PW-1:0]        ch_p    [NUM_CELLS+1][2];
	logic [PW-1:0]        ch_q    [NUM_CELLS+1][2];
	logic [MAG_W-1:0]     ch_acc  [NUM_CELLS+1][2];
	logic [SW-1:0]        ch_side [NUM_CELLS+1];

	logic signed [W-1:0]  ax, ay, bx, by;
	logic                 dy_neg, dx_pos, degen;
	logic signed [EW-1:0] rx, ry;
	logic signed [W-1:0]  cor [8];
	logic signed [W-1:0]  cor_q [8];
	logic                 done_q, degen_q, v_s1;

	function automatic logic signed [W-1:0] sat(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] hi;
		logic signed [EW-1:0] lo;
		hi = EW'((64'(1) << (W - 1)) - 64'(1));
		lo = -hi - EW'(1);
		if (v > hi) begin
			sat = hi[W-1:0];
		end else if (v < lo) begin
			sat = lo[W-1:0];
		end else begin
			sat = v[W-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= '0;
			offx_q  <= '0;
			offy_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_THICKNESS: thick_q <= cfg_wdata[THICK_W-1:0];
				CFG_OFFSET_X:  offx_q  <= cfg_wdata[W-1:0];
				CFG_OFFSET_Y:  offy_q  <= cfg_wdata[W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	tlqe_prep #(.W(W), .PW(PW), .SW(SW)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.ax        (start_x),
		.ay        (start_y),
		.bx        (end_x),
		.by        (end_y),
		.thickness (thick_q),
		.out_ctl   (ch_ctl[0]),
		.out_s     (ch_s[0]),
		.out_c     (ch_c[0]),
		.out_side  (ch_side[0])
	);

	assign v_s1 = u_prep.v_s1;

	for (genvar l = 0; l < 2; l++) begin : g_head
		assign ch_p[0][l]   = ch_s[0];
		assign ch_q[0][l]   = -ch_s[0];
		assign ch_acc[0][l] = '0;
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		tlqe_cell #(.PW(PW), .SW(SW), .BIT(NUM_CELLS - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_ctl   (ch_ctl[i]),
			.in_s     (ch_s[i]),
			.in_c     (ch_c[i]),
			.in_p     (ch_p[i]),
			.in_q     (ch_q[i]),
			.in_acc   (ch_acc[i]),
			.in_side  (ch_side[i]),
			.out_ctl  (ch_ctl[i+1]),
			.out_s    (ch_s[i+1]),
			.out_c    (ch_c[i+1]),
			.out_p    (ch_p[i+1]),
			.out_q    (ch_q[i+1]),
			.out_acc  (ch_acc[i+1]),
			.out_side (ch_side[i+1])
		);
	end

	assign {degen, dx_pos, dy_neg, by, bx, ay, ax} = ch_side[NUM_CELLS];

	always_comb begin
		rx = degen ? '0 : (dy_neg ? -EW'(ch_acc[NUM_CELLS][0]) : EW'(ch_acc[NUM_CELLS][0]));
		ry = degen ? '0 : (dx_pos ? -EW'(ch_acc[NUM_CELLS][1]) : EW'(ch_acc[NUM_CELLS][1]));
		cor[0] = sat(EW'(bx) + rx + EW'(offx_q));
		cor[1] = sat(EW'(by) + ry + EW'(offy_q));
		cor[2] = sat(EW'(ax) + rx + EW'(offx_q));
		cor[3] = sat(EW'(ay) + ry + EW'(offy_q));
		cor[4] = sat(EW'(ax) - rx + EW'(offx_q));
		cor[5] = sat(EW'(ay) - ry + EW'(offy_q));
		cor[6] = sat(EW'(bx) - rx + EW'(offx_q));
		cor[7] = sat(EW'(by) - ry + EW'(offy_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ch_ctl[NUM_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		cor_q   <= cor;
		degen_q <= degen;
	end

	assign done       = done_q;
	assign degenerate = degen_q;
	assign corner0_x  = cor_q[0];
	assign corner0_y  = cor_q[1];
	assign corner1_x  = cor_q[2];
	assign corner1_y  = cor_q[3];
	assign corner2_x  = cor_q[4];
	assign corner2_y  = cor_q[5];
	assign corner3_x  = cor_q[6];
	assign corner3_y  = cor_q[7];

	`TLQE_ASSERT_NXT(a_req_enters, clk, arst_n, start && !busy, v_s1)
	`TLQE_ASSERT_IMP(a_latency, clk, arst_n, 1'b1, done == $past(v_s1, LAT - 1))
	`TLQE_ASSERT_IMP(a_degen_collapse, clk, arst_n, done && degenerate, (corner0_x == corner1_x) && (corner1_x == corner2_x) && (corner2_x == corner3_x) && (corner0_y == corner1_y) && (corner1_y == corner2_y) && (corner2_y == corner3_y))

endmodule
